FILE: src/calendar_date_set_editor_defines.svh
// Assertion macros shared by the calendar date editor RTL.
`ifndef CALENDAR_DATE_SET_EDITOR_DEFINES_SVH
`define CALENDAR_DATE_SET_EDITOR_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CDSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that must also hold during reset.
`define CDSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: src/cdse_pkg.sv
// Types, codes and calendar helper functions for the calendar date editor.
package cdse_pkg;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_INC     = 3'd1,
    OP_DEC     = 3'd2,
    OP_CONFIRM = 3'd3,
    OP_NEXT    = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    FIELD_YEAR    = 2'd0,
    FIELD_MONTH   = 2'd1,
    FIELD_DAY     = 2'd2,
    FIELD_WEEKDAY = 2'd3
  } field_e;

  localparam logic [6:0] YEAR_MAX    = 7'd99;
  localparam logic [6:0] YEAR_CENT   = 7'd100;
  localparam logic [3:0] MONTH_MAX   = 4'd12;
  localparam logic [3:0] MONTH_FEB   = 4'd2;
  localparam logic [4:0] DAY_LEAP    = 5'd29;
  localparam logic [4:0] DAY_COMMON  = 5'd28;
  localparam logic [2:0] WEEKDAY_MAX = 3'd7;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    field_e     field;
  } date_t;

  // The year is 2000 plus a 7-bit offset. Since 2000 is a multiple of 400,
  // the only offset that is a multiple of 4 but not a leap year is 100.
  function automatic logic is_leap(input logic [6:0] yy);
    is_leap = (yy[1:0] == 2'd0) && (yy != YEAR_CENT);
  endfunction

  // Out of range months count as 31-day months.
  function automatic logic [4:0] month_len(input logic [6:0] yy, input logic [3:0] mm);
    case (mm)
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      MONTH_FEB:               month_len = is_leap(yy) ? DAY_LEAP : DAY_COMMON;
      default:                 month_len = 5'd31;
    endcase
  endfunction

endpackage

FILE: src/cdse_update.sv
// Next-state logic of the date editor for one key event.
module cdse_update (
  input  cdse_pkg::date_t cur_i,
  input  logic [2:0]      opcode_i,
  input  logic [6:0]      load_year_i,
  input  logic [3:0]      load_month_i,
  input  logic [4:0]      load_day_i,
  input  logic [2:0]      load_weekday_i,
  output cdse_pkg::date_t nxt_o,
  output logic            commit_o
);
  import cdse_pkg::*;

  logic       up;
  logic [6:0] year_adj;
  logic [3:0] month_adj;
  logic [4:0] len_cur;
  logic [4:0] len_new_month;
  logic [4:0] day_adj;
  logic [4:0] day_after_year;
  logic [4:0] day_after_month;
  logic [2:0] weekday_adj;
  date_t      adj;

  assign up = (opcode_i == OP_INC);

  always_comb begin
    if (up) begin
      year_adj = (cur_i.year >= YEAR_MAX) ? 7'd0 : 7'(cur_i.year + 7'd1);
    end else begin
      year_adj = (cur_i.year == 7'd0) ? YEAR_MAX : 7'(cur_i.year - 7'd1);
    end
    if (up) begin
      month_adj = (cur_i.month >= MONTH_MAX) ? 4'd1 : 4'(cur_i.month + 4'd1);
    end else begin
      month_adj = (cur_i.month <= 4'd1) ? MONTH_MAX : 4'(cur_i.month - 4'd1);
    end
    len_cur = month_len(cur_i.year, cur_i.month);
    if (up) begin
      day_adj = (cur_i.day >= len_cur) ? 5'd1 : 5'(cur_i.day + 5'd1);
    end else begin
      day_adj = (cur_i.day <= 5'd1) ? len_cur : 5'(cur_i.day - 5'd1);
    end
    if (up) begin
      weekday_adj = (cur_i.weekday >= WEEKDAY_MAX) ? 3'd1 : 3'(cur_i.weekday + 3'd1);
    end else begin
      weekday_adj = (cur_i.weekday <= 3'd1) ? WEEKDAY_MAX : 3'(cur_i.weekday - 3'd1);
    end

    // A year change only touches 29 February.
    day_after_year = cur_i.day;
    if (cur_i.month == MONTH_FEB && cur_i.day == DAY_LEAP && !is_leap(year_adj)) begin
      day_after_year = DAY_COMMON;
    end

    // A month change clamps the day to the new month length.
    len_new_month   = month_len(cur_i.year, month_adj);
    day_after_month = (cur_i.day > len_new_month) ? len_new_month : cur_i.day;

    adj = cur_i;
    case (cur_i.field)
      FIELD_YEAR: begin
        adj.year = year_adj;
        adj.day  = day_after_year;
      end
      FIELD_MONTH: begin
        adj.month = month_adj;
        adj.day   = day_after_month;
      end
      FIELD_DAY: begin
        adj.day = day_adj;
      end
      default: begin
        adj.weekday = weekday_adj;
      end
    endcase
  end

  always_comb begin
    nxt_o    = cur_i;
    commit_o = 1'b0;
    case (opcode_i)
      OP_LOAD: begin
        nxt_o.year    = load_year_i;
        nxt_o.month   = load_month_i;
        nxt_o.day     = load_day_i;
        nxt_o.weekday = (load_weekday_i == 3'd0) ? 3'd1 : load_weekday_i;
        nxt_o.field   = FIELD_YEAR;
      end
      OP_INC, OP_DEC: begin
        nxt_o = adj;
      end
      OP_CONFIRM: begin
        commit_o    = 1'b1;
        nxt_o.field = FIELD_YEAR;
      end
      OP_NEXT: begin
        nxt_o.field = field_e'(2'(cur_i.field + 2'd1));
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

FILE: src/calendar_date_set_editor.sv
// Top level of the key-driven calendar date editor.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+--------------------------------------
//   in      | input     | in_valid_i, in_stall_o   | opcode_i, load_year/month/day/weekday
//   out     | output    | out_valid_o, out_stall_i | year/month/day/weekday, field, commit
//
// Every input transaction produces exactly one output transaction. A transaction
// accepted into the input register passes one level of update logic and loads
// the result register once the pipeline advances, so its result is offered from
// the result register; one transaction per cycle is sustained and only the
// output stall slows it. Reset is asynchronous, active low, and clears the date
// to zero with weekday one and the year field selected. in_stall_o rises only
// while a result waits under out_stall_i and the input register is also occupied.
`include "calendar_date_set_editor_defines.svh"

module calendar_date_set_editor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] opcode_i,
  input  logic [6:0] load_year_i,
  input  logic [3:0] load_month_i,
  input  logic [4:0] load_day_i,
  input  logic [2:0] load_weekday_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] year_out_o,
  output logic [3:0] month_out_o,
  output logic [4:0] day_out_o,
  output logic [2:0] weekday_out_o,
  output logic [1:0] field_select_o,
  output logic       commit_o
);
  import cdse_pkg::*;

  // Input register.
  logic       in_valid_q;
  logic [2:0] opcode_q;
  logic [6:0] load_year_q;
  logic [3:0] load_month_q;
  logic [4:0] load_day_q;
  logic [2:0] load_weekday_q;

  // Edited date and the result register.
  date_t state_q, state_d;
  date_t res_q;
  logic  commit_q, commit_d;
  logic  out_valid_q;

  logic  advance;
  logic  in_take;

  // The pipeline moves whenever the result register is free or drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Payload registers carry no reset; they load only on an accepted transaction.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      opcode_q       <= opcode_i;
      load_year_q    <= load_year_i;
      load_month_q   <= load_month_i;
      load_day_q     <= load_day_i;
      load_weekday_q <= load_weekday_i;
    end
  end

  cdse_update u_update (
    .cur_i          (state_q),
    .opcode_i       (opcode_q),
    .load_year_i    (load_year_q),
    .load_month_i   (load_month_q),
    .load_day_i     (load_day_q),
    .load_weekday_i (load_weekday_q),
    .nxt_o          (state_d),
    .commit_o       (commit_d)
  );

  // The date state is part of control: it must start from a known date.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{year: 7'd0, month: 4'd0, day: 5'd0, weekday: 3'd1,
                       field: FIELD_YEAR};
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q    <= state_d;
      commit_q <= commit_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign year_out_o     = res_q.year;
  assign month_out_o    = res_q.month;
  assign day_out_o      = res_q.day;
  assign weekday_out_o  = res_q.weekday;
  assign field_select_o = res_q.field;
  assign commit_o       = commit_q;

  `CDSE_ASSERT(a_weekday_nonzero, state_q.weekday != 3'd0, "edited weekday became zero")
  `CDSE_ASSERT(a_stall_only_when_full, in_stall_o |-> (out_valid_o && out_stall_i),
               "input stalled while result register free")
  `CDSE_ASSERT(a_in_held, (in_valid_q && !advance) |=> in_valid_q,
               "held input transaction was dropped")
  `CDSE_ASSERT(a_confirm_result,
               (advance && in_valid_q && opcode_q == OP_CONFIRM) |=>
               (out_valid_o && commit_o && field_select_o == FIELD_YEAR),
               "confirm did not commit and return to year field")

endmodule

FILE: sim/cdse_result_checker.sv
// Watches both channels of the date editor, predicts each result and compares it.
module cdse_result_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [2:0] opcode_i,
  input  logic [6:0] load_year_i,
  input  logic [3:0] load_month_i,
  input  logic [4:0] load_day_i,
  input  logic [2:0] load_weekday_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [6:0] year_out_i,
  input  logic [3:0] month_out_i,
  input  logic [4:0] day_out_i,
  input  logic [2:0] weekday_out_i,
  input  logic [1:0] field_select_i,
  input  logic       commit_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import cdse_pkg::*;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    logic [1:0] field;
    logic       commit;
  } date_view_t;

  logic [6:0] cur_year    = '0;
  logic [3:0] cur_month   = '0;
  logic [4:0] cur_day     = '0;
  logic [2:0] cur_weekday = 3'd1;
  logic [1:0] cur_field   = FIELD_YEAR;

  date_view_t expected_dates_q[$];
  int         mismatches = 0;

  assign fail_count_o = mismatches;

  // Leap rule on the full four-digit year, so offsets above 99 behave as in a real calendar.
  function automatic bit leap_year(input logic [6:0] yy);
    int full;
    full = 2000 + int'(yy);
    return ((full % 4 == 0) && (full % 100 != 0)) || (full % 400 == 0);
  endfunction

  function automatic logic [4:0] days_in_month(input logic [6:0] yy, input logic [3:0] mm);
    case (mm)
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      MONTH_FEB:               return leap_year(yy) ? DAY_LEAP : DAY_COMMON;
      default:                 return 5'd31;
    endcase
  endfunction

  task automatic step_selected_field(input bit up);
    logic [4:0] len;
    case (field_e'(cur_field))
      FIELD_YEAR: begin
        if (up) cur_year = (cur_year >= YEAR_MAX) ? 7'd0 : cur_year + 7'd1;
        else    cur_year = (cur_year == 7'd0) ? YEAR_MAX : cur_year - 7'd1;
        // Only a 29 February is pulled back when the new year is a common year.
        if (cur_month == MONTH_FEB && cur_day == DAY_LEAP &&
            cur_day > days_in_month(cur_year, cur_month))
          cur_day = days_in_month(cur_year, cur_month);
      end
      FIELD_MONTH: begin
        if (up) cur_month = (cur_month >= MONTH_MAX) ? 4'd1 : cur_month + 4'd1;
        else    cur_month = (cur_month <= 4'd1) ? MONTH_MAX : cur_month - 4'd1;
        if (cur_day > days_in_month(cur_year, cur_month))
          cur_day = days_in_month(cur_year, cur_month);
      end
      FIELD_DAY: begin
        len = days_in_month(cur_year, cur_month);
        if (up) cur_day = (cur_day >= len) ? 5'd1 : cur_day + 5'd1;
        else    cur_day = (cur_day <= 5'd1) ? len : cur_day - 5'd1;
      end
      default: begin
        if (up) cur_weekday = (cur_weekday >= WEEKDAY_MAX) ? 3'd1 : cur_weekday + 3'd1;
        else    cur_weekday = (cur_weekday <= 3'd1) ? WEEKDAY_MAX : cur_weekday - 3'd1;
      end
    endcase
  endtask

  // Applies one key event to the edited date and queues the date it leaves behind.
  task automatic apply_key_event();
    date_view_t nxt;
    logic       commit_flag;
    commit_flag = 1'b0;
    case (opcode_e'(opcode_i))
      OP_LOAD: begin
        cur_year    = load_year_i;
        cur_month   = load_month_i;
        cur_day     = load_day_i;
        cur_weekday = (load_weekday_i == 3'd0) ? 3'd1 : load_weekday_i;
        cur_field   = FIELD_YEAR;
      end
      OP_INC:     step_selected_field(1'b1);
      OP_DEC:     step_selected_field(1'b0);
      OP_CONFIRM: begin
        commit_flag = 1'b1;
        cur_field   = FIELD_YEAR;
      end
      OP_NEXT:    cur_field = cur_field + 2'd1;
      default:    ;
    endcase
    nxt.year    = cur_year;
    nxt.month   = cur_month;
    nxt.day     = cur_day;
    nxt.weekday = cur_weekday;
    nxt.field   = cur_field;
    nxt.commit  = commit_flag;
    expected_dates_q.push_back(nxt);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : watch_channels
    date_view_t want;
    if (!rst_ni) begin
      cur_year    = '0;
      cur_month   = '0;
      cur_day     = '0;
      cur_weekday = 3'd1;
      cur_field   = FIELD_YEAR;
      expected_dates_q.delete();
    end else begin
      // The result side goes first; an input taken at this edge cannot
      // produce a result at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (expected_dates_q.size() == 0) begin
          $error("result transaction arrived with no expected date pending");
          mismatches++;
        end else begin
          want = expected_dates_q.pop_front();
          check_field("year_out",     want.year,    year_out_i);
          check_field("month_out",    want.month,   month_out_i);
          check_field("day_out",      want.day,     day_out_i);
          check_field("weekday_out",  want.weekday, weekday_out_i);
          check_field("field_select", want.field,   field_select_i);
          check_field("commit",       want.commit,  commit_i);
        end
      end
      if (in_valid_i && !in_stall_i) apply_key_event();
    end
    pending_o = expected_dates_q.size();
  end

endmodule

FILE: sim/tb_calendar_date_set_editor.sv
// Stimulus, reset, watchdog and verdict for the calendar date editor.
module tb_calendar_date_set_editor;
  timeunit 1ns;
  timeprecision 1ps;

  import cdse_pkg::*;

  // Number of random key events after the directed part.
  localparam int RANDOM_EVENTS = 1200;
  // Cycles the receiver refuses results during the pressure phase.
  localparam int HOLD_CYCLES   = 300;
  // Cycles without any accepted transaction before the run is declared hung.
  // The longest legal quiet spell is the pressure hold plus a few random stalls.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles to wait after the last result.
  localparam int DRAIN_CYCLES  = 10;

  logic       clk_i;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic [2:0] opcode_i       = OP_LOAD;
  logic [6:0] load_year_i    = '0;
  logic [3:0] load_month_i   = '0;
  logic [4:0] load_day_i     = '0;
  logic [2:0] load_weekday_i = '0;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic [6:0] year_out_o;
  logic [3:0] month_out_o;
  logic [4:0] day_out_o;
  logic [2:0] weekday_out_o;
  logic [1:0] field_select_o;
  logic       commit_o;

  int check_fails;
  int dates_pending;

  // Shared knobs: idle_on turns random idling on for both sides, and
  // hold_req asks the receiver for one long hold-off.
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int events_sent = 0;

  calendar_date_set_editor dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .load_year_i    (load_year_i),
    .load_month_i   (load_month_i),
    .load_day_i     (load_day_i),
    .load_weekday_i (load_weekday_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .year_out_o     (year_out_o),
    .month_out_o    (month_out_o),
    .day_out_o      (day_out_o),
    .weekday_out_o  (weekday_out_o),
    .field_select_o (field_select_o),
    .commit_o       (commit_o)
  );

  cdse_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .opcode_i       (opcode_i),
    .load_year_i    (load_year_i),
    .load_month_i   (load_month_i),
    .load_day_i     (load_day_i),
    .load_weekday_i (load_weekday_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .year_out_i     (year_out_o),
    .month_out_i    (month_out_o),
    .day_out_i      (day_out_o),
    .weekday_out_i  (weekday_out_o),
    .field_select_i (field_select_o),
    .commit_i       (commit_o),
    .fail_count_o   (check_fails),
    .pending_o      (dates_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one key event and holds it until the block takes it. The task is
  // entered and left at a falling edge, where all inputs change. When the
  // next event follows at once, valid simply stays high; it is only written
  // low in a step where no new event is offered.
  task automatic send_event(input logic [2:0] op, input logic [6:0] yy, input logic [3:0] mm,
                            input logic [4:0] dd, input logic [2:0] wd);
    while (idle_on && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    load_year_i    <= yy;
    load_month_i   <= mm;
    load_day_i     <= dd;
    load_weekday_i <= wd;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    events_sent++;
  endtask

  // Key events other than load carry random payload bits, which the block ignores.
  task automatic send_key(input logic [2:0] op);
    send_event(op, 7'($urandom), 4'($urandom), 5'($urandom), 3'($urandom));
  endtask

  // Loads are mostly plausible dates, with a share of 29 February and a
  // share of raw bit patterns that reach the out-of-range months, days and years.
  task automatic send_random_load();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0)
      send_key(OP_LOAD);
    else if (pick == 1)
      send_event(OP_LOAD, 7'($urandom_range(127)), MONTH_FEB, DAY_LEAP, 3'($urandom));
    else
      send_event(OP_LOAD, 7'($urandom_range(99)), 4'($urandom_range(1, 12)),
                 5'($urandom_range(1, 31)), 3'($urandom));
  endtask

  // Editing keys: mostly steps and field changes, some confirms, and a few
  // unused opcodes as noise.
  task automatic send_random_edit();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35)      send_key(OP_INC);
    else if (pick < 70) send_key(OP_DEC);
    else if (pick < 88) send_key(OP_NEXT);
    else if (pick < 95) send_key(OP_CONFIRM);
    else                send_key(3'($urandom_range(5, 7)));
  endtask

  // Receiver: random stalls while idling is on, and one long hold-off on
  // request, counted here so that the sender keeps offering meanwhile.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < 33);
      end
    end
  end

  // Watchdog: any cycle with an accepted transaction on either side resets the count.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int burst_len;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Bit extremes on every load field, with weekday zero promoted to one.
    send_event(OP_LOAD, 7'd99, 4'd12, 5'd31, 3'd7);
    send_key(OP_INC);                                   // year wraps from 99 to 0
    send_key(OP_DEC);                                   // and back from 0 to 99
    send_event(OP_LOAD, 7'd127, 4'd15, 5'd31, 3'd7);    // all load bits high
    send_key(OP_INC);                                   // year above 99 steps to 0
    send_key(OP_NEXT);
    send_key(OP_INC);                                   // month above 12 steps to 1
    send_event(OP_LOAD, 7'd0, 4'd0, 5'd0, 3'd0);        // all load bits low
    send_key(OP_NEXT);
    send_key(OP_DEC);                                   // month 0 steps down to 12
    send_key(OP_NEXT);
    send_key(OP_DEC);                                   // day 0 steps down to month length
    send_key(OP_INC);                                   // and wraps up to 1
    send_key(OP_NEXT);
    send_key(OP_DEC);                                   // weekday 1 wraps to 7
    send_key(OP_INC);                                   // weekday 7 wraps to 1
    send_key(OP_NEXT);                                  // field select wraps to year
    // Year 2100 is a common year: leaving it downward keeps 29 February
    // only if the new year is a leap year, and 2099 is not.
    send_event(OP_LOAD, 7'd100, MONTH_FEB, DAY_LEAP, 3'd3);
    send_key(OP_DEC);
    // 29 February in a common year survives a step into a leap year.
    send_event(OP_LOAD, 7'd3, MONTH_FEB, DAY_LEAP, 3'd1);
    send_key(OP_INC);
    // A month change from 31 January clamps the day to 29 February in 2000.
    send_event(OP_LOAD, 7'd0, 4'd1, 5'd31, 3'd5);
    send_key(OP_NEXT);
    send_key(OP_INC);
    send_key(OP_CONFIRM);                               // commit and back to year field
    send_key(3'd5);                                     // unused opcodes change nothing
    send_key(3'd7);

    // Random part: bursts that start with a load and then edit, with an
    // occasional burst that edits whatever date is left from before.
    // The middle third runs without idling and holds the receiver off at least once.
    while (events_sent < RANDOM_EVENTS + 30) begin
      idle_on = !(events_sent >= 430 && events_sent < 830);
      if (events_sent >= 530 && events_sent < 560) hold_req = 1'b1;
      if ($urandom_range(9) != 0) send_random_load();
      burst_len = $urandom_range(2, 20);
      repeat (burst_len) send_random_edit();
    end
    in_valid_i <= 1'b0;

    // Wait for every expected date, then a few more cycles so that any
    // stray result still shows up in the checker.
    do @(negedge clk_i); while (dates_pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (check_fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
